### rtl/acv_pkg.sv
`timescale 1ns / 1ps

package acv_pkg;

  // Request kinds carried in tuser of the input channel.
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_PUSH  = 2'd1;
  localparam logic [1:0] REQ_EVAL  = 2'd2;
  localparam logic [1:0] REQ_SPARE = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_NOT_LOADED = 2'd1;
  localparam logic [1:0] STAT_SAT        = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_LAGS = 1'b0;
  localparam logic CFG_NORM = 1'b1;

  localparam logic [8:0]  LAGS_RESET = 9'd200;
  localparam logic [23:0] NORM_RESET = 24'd65536;
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;

  // Datapath word widths.
  localparam int SQ_W  = 96;   // |a|^2
  localparam int NUM_W = 120;  // dividend
  localparam int DEN_W = 62;   // divisor
  localparam int Q_W   = 32;   // quotient bits

  typedef enum logic [4:0] {
    OP_NOP, OP_M2_R, OP_M2_I, OP_M2_SUM, OP_LD, OP_CC, OP_DEN1, OP_P0, OP_P1, OP_A,
    OP_Z_SQ, OP_Z_X, OP_Z_NUM, OP_S_LL, OP_S_LH, OP_S_HH, OP_S_SQ,
    OP_N0, OP_N1, OP_N2, OP_N3, OP_N4, OP_DEN, OP_DIV_INIT, OP_DIV_STEP, OP_ACC, OP_WAIT
  } dp_op_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_RUN, ST_OUT
  } ctl_state_t;

  typedef struct packed {
    dp_op_t op;
    logic   accept;
    logic   out_load;
    logic   out_nl;
  } dp_cmd_t;

  typedef struct packed {
    logic loaded;
    logic lags_zero;
    logic m2_zero;
    logic last_lag;
  } dp_status_t;

endpackage

### rtl/autocorr_chisq_veto.sv
`timescale 1ns / 1ps
// Coefficient loads and sample pushes give no result. During an evaluation
// each of the L lags runs through the shared 33x33 multiplier and a 32-step,
// one-bit-per-cycle divider. One item is in work at a time.
// Reset (rst_n low, synchronous) empties the delay line and the table flag and
// restores lags_in_use to 200 and norm_scale to 1.0.
module autocorr_chisq_veto #(
  parameter int MAX_LAGS  = 256,
  parameter int TEMPLATES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // template_index[3:0], lag_index[11:4], coefficient[27:12],
  // sample_re[43:28], sample_im[59:44], zero fill
  input  logic [63:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // chisq_value[31:0], degrees_free[40:32], zero fill
  output logic [47:0] out_tdata,
  // status_code[1:0]
  output logic [1:0]  out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);
  import acv_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [31:0] chisq_value;
  logic [8:0]  degrees_free;

  assign cfg_ready = 1'b1;
  assign out_tdata = {7'd0, degrees_free, chisq_value};

  acv_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_req     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  acv_dp #(.MAX_LAGS(MAX_LAGS), .TEMPLATES(TEMPLATES)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .req_type       (in_tuser),
    .template_index (in_tdata[3:0]),
    .lag_index      (in_tdata[11:4]),
    .coefficient    (in_tdata[27:12]),
    .sample_re      (in_tdata[43:28]),
    .sample_im      (in_tdata[59:44]),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .chisq_value    (chisq_value),
    .degrees_free   (degrees_free),
    .status_code    (out_tuser)
  );

endmodule

### rtl/acv_ram.sv
`timescale 1ns / 1ps

module acv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/acv_ctrl.sv
`timescale 1ns / 1ps

module acv_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [1:0]          in_req,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  acv_pkg::dp_status_t status,
  output acv_pkg::dp_cmd_t    cmd
);
  import acv_pkg::*;

  ctl_state_t state_r, state_nxt;
  dp_op_t     op_r, op_nxt;
  logic [4:0] div_cnt_r, div_cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       nl_r, nl_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_NOP;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      nl_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      nl_r        <= nl_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    div_cnt_nxt   = div_cnt_r;
    nl_nxt        = nl_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.op        = OP_NOP;
    cmd.accept    = 1'b0;
    cmd.out_load  = 1'b0;
    cmd.out_nl    = nl_r;

    unique case (state_r)
      ST_IDLE: begin
        cmd.accept = in_tvalid;
        if (in_tvalid && in_req == REQ_EVAL) begin
          if (status.loaded) begin
            state_nxt = ST_RUN;
            op_nxt    = OP_M2_R;
            nl_nxt    = 1'b0;
          end else begin
            state_nxt = ST_OUT;
            nl_nxt    = 1'b1;
          end
        end
      end
      ST_RUN: begin
        cmd.op = op_r;
        unique case (op_r)
          OP_M2_R:   op_nxt = OP_M2_I;
          OP_M2_I:   op_nxt = OP_M2_SUM;
          OP_M2_SUM: begin
            if (status.lags_zero) begin
              state_nxt = ST_OUT;
            end else begin
              op_nxt = OP_LD;
            end
          end
          OP_LD:     op_nxt = OP_CC;
          OP_CC:     op_nxt = OP_DEN1;
          OP_DEN1:   op_nxt = OP_P0;
          OP_P0:     op_nxt = OP_P1;
          OP_P1:     op_nxt = OP_A;
          OP_A:      op_nxt = status.m2_zero ? OP_Z_SQ : OP_S_LL;
          OP_Z_SQ:   op_nxt = OP_Z_X;
          OP_Z_X:    op_nxt = OP_Z_NUM;
          OP_Z_NUM:  op_nxt = OP_DIV_INIT;
          OP_S_LL:   op_nxt = OP_S_LH;
          OP_S_LH:   op_nxt = OP_S_HH;
          OP_S_HH:   op_nxt = OP_S_SQ;
          OP_S_SQ:   op_nxt = OP_N0;
          OP_N0:     op_nxt = OP_N1;
          OP_N1:     op_nxt = OP_N2;
          OP_N2:     op_nxt = OP_N3;
          OP_N3:     op_nxt = OP_N4;
          OP_N4:     op_nxt = OP_DEN;
          OP_DEN:    op_nxt = OP_DIV_INIT;
          OP_DIV_INIT: begin
            op_nxt      = OP_DIV_STEP;
            div_cnt_nxt = '0;
          end
          OP_DIV_STEP: begin
            div_cnt_nxt = div_cnt_r + 5'd1;
            if (div_cnt_r == 5'(Q_W - 1)) begin
              op_nxt = OP_ACC;
            end
          end
          OP_ACC: begin
            if (status.last_lag) begin
              state_nxt = ST_OUT;
            end else begin
              op_nxt = OP_WAIT;
            end
          end
          // The OP_WAIT state lets the memories return the next lag's words.
          OP_WAIT:   op_nxt = OP_LD;
          default:   state_nxt = ST_IDLE;
        endcase
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### rtl/acv_dp.sv
`timescale 1ns / 1ps

module acv_dp #(
  parameter int MAX_LAGS  = 256,
  parameter int TEMPLATES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  acv_pkg::dp_cmd_t     cmd,
  output acv_pkg::dp_status_t  status,
  input  logic [1:0]           req_type,
  input  logic [3:0]           template_index,
  input  logic [7:0]           lag_index,
  input  logic signed [15:0]   coefficient,
  input  logic signed [15:0]   sample_re,
  input  logic signed [15:0]   sample_im,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [23:0]          cfg_data,
  output logic [31:0]          chisq_value,
  output logic [8:0]           degrees_free,
  output logic [1:0]           status_code
);
  import acv_pkg::*;

  localparam int DEPTH = MAX_LAGS + 1;
  localparam int HW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int KW    = $clog2(MAX_LAGS + 1);
  localparam int LW    = (MAX_LAGS > 1) ? $clog2(MAX_LAGS) : 1;
  localparam int TW    = (TEMPLATES > 1) ? $clog2(TEMPLATES) : 1;
  localparam int CDEP  = TEMPLATES * MAX_LAGS;
  localparam int CAW   = (CDEP > 1) ? $clog2(CDEP) : 1;

  // Template index wrap as a constant table.
  logic [TW-1:0] tmod_lut [16];
  for (genvar g = 0; g < 16; g++) begin : g_tmod
    assign tmod_lut[g] = TW'(g % TEMPLATES);
  end

  // Control state.
  logic [HW-1:0]  head_r, head_nxt, head_inc;
  logic [CW-1:0]  hist_cnt_r, hist_cnt_nxt;
  logic           loaded_r, loaded_nxt;
  logic [8:0]     lags_cfg_r, lags_cfg_nxt;
  logic [23:0]    norm_r, norm_nxt;

  // Evaluation payload.
  logic signed [15:0] r0_r, r0_nxt, i0_r, i0_nxt;
  logic [31:0]        m2_r, m2_nxt;
  logic [CAW-1:0]     cbase_r, cbase_nxt;
  logic [KW-1:0]      lags_r, lags_nxt, k_r, k_nxt;
  logic [HW-1:0]      hptr_r, hptr_nxt;
  logic signed [15:0] c_r, c_nxt, rk_r, rk_nxt, ik_r, ik_nxt;
  logic [30:0]        den1_r, den1_nxt;
  logic signed [32:0] p_r, p_nxt;
  logic [47:0]        ua_r, ua_nxt;
  logic [SQ_W-1:0]    sq_r, sq_nxt;
  logic [NUM_W-1:0]   num_r, num_nxt;
  logic [DEN_W-1:0]   den_r, den_nxt, rem_r, rem_nxt;
  logic [Q_W-1:0]     q_r, q_nxt;
  logic               tsat_r, tsat_nxt, sat_r, sat_nxt;
  logic [31:0]        sum_r, sum_nxt;
  logic [8:0]         dof_r, dof_nxt;
  logic signed [65:0] prod_r, prod_nxt;
  logic [31:0]        chisq_r, chisq_nxt;
  logic [8:0]         dofo_r, dofo_nxt;
  logic [1:0]         stat_r, stat_nxt;

  logic signed [32:0] mul_a, mul_b;
  logic signed [48:0] a_v;
  logic [DEN_W:0]     rem2;
  logic [32:0]        sum_v;
  logic               hist_ok;
  logic [TW-1:0]      tmpl;

  // Memories.
  logic               hist_we, coef_we;
  logic [31:0]        hist_rd;
  logic [15:0]        coef_rd;
  logic [CAW-1:0]     coef_waddr, coef_raddr;

  assign tmpl       = tmod_lut[template_index];
  assign head_inc   = (head_r == HW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign coef_waddr = CAW'(int'(tmpl) * MAX_LAGS + int'(lag_index));
  assign coef_raddr = cbase_r + CAW'(k_r[LW-1:0]);
  assign hist_ok    = ((CW + 1)'(k_r) + 1'b1) < (CW + 1)'(hist_cnt_r);

  acv_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (head_inc),
    .wdata ({sample_im, sample_re}),
    .raddr (hptr_r),
    .rdata (hist_rd)
  );

  acv_ram #(.WIDTH(16), .DEPTH(CDEP)) u_coef (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coefficient),
    .raddr (coef_raddr),
    .rdata (coef_rd)
  );

  assign status.loaded    = loaded_r;
  assign status.lags_zero = (lags_r == '0);
  assign status.m2_zero   = (m2_r == '0);
  assign status.last_lag  = ((KW + 1)'(k_r) + 1'b1) == (KW + 1)'(lags_r);

  assign chisq_value  = chisq_r;
  assign degrees_free = dofo_r;
  assign status_code  = stat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      hist_cnt_r <= '0;
      loaded_r   <= 1'b0;
      lags_cfg_r <= LAGS_RESET;
      norm_r     <= NORM_RESET;
    end else begin
      head_r     <= head_nxt;
      hist_cnt_r <= hist_cnt_nxt;
      loaded_r   <= loaded_nxt;
      lags_cfg_r <= lags_cfg_nxt;
      norm_r     <= norm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r0_r    <= r0_nxt;
    i0_r    <= i0_nxt;
    m2_r    <= m2_nxt;
    cbase_r <= cbase_nxt;
    lags_r  <= lags_nxt;
    k_r     <= k_nxt;
    hptr_r  <= hptr_nxt;
    c_r     <= c_nxt;
    rk_r    <= rk_nxt;
    ik_r    <= ik_nxt;
    den1_r  <= den1_nxt;
    p_r     <= p_nxt;
    ua_r    <= ua_nxt;
    sq_r    <= sq_nxt;
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    tsat_r  <= tsat_nxt;
    sat_r   <= sat_nxt;
    sum_r   <= sum_nxt;
    dof_r   <= dof_nxt;
    prod_r  <= prod_nxt;
    chisq_r <= chisq_nxt;
    dofo_r  <= dofo_nxt;
    stat_r  <= stat_nxt;
  end

  // The one shared multiplier; its product is always registered.
  assign prod_nxt = mul_a * mul_b;

  always_comb begin
    head_nxt     = head_r;
    hist_cnt_nxt = hist_cnt_r;
    loaded_nxt   = loaded_r;
    lags_cfg_nxt = lags_cfg_r;
    norm_nxt     = norm_r;
    r0_nxt       = r0_r;
    i0_nxt       = i0_r;
    m2_nxt       = m2_r;
    cbase_nxt    = cbase_r;
    lags_nxt     = lags_r;
    k_nxt        = k_r;
    hptr_nxt     = hptr_r;
    c_nxt        = c_r;
    rk_nxt       = rk_r;
    ik_nxt       = ik_r;
    den1_nxt     = den1_r;
    p_nxt        = p_r;
    ua_nxt       = ua_r;
    sq_nxt       = sq_r;
    num_nxt      = num_r;
    den_nxt      = den_r;
    rem_nxt      = rem_r;
    q_nxt        = q_r;
    tsat_nxt     = tsat_r;
    sat_nxt      = sat_r;
    sum_nxt      = sum_r;
    dof_nxt      = dof_r;
    chisq_nxt    = chisq_r;
    dofo_nxt     = dofo_r;
    stat_nxt     = stat_r;
    mul_a        = '0;
    mul_b        = '0;
    hist_we      = 1'b0;
    coef_we      = 1'b0;
    a_v          = (49'(p_r) <<< 15) - signed'(prod_r[48:0]);
    rem2         = {rem_r, num_r[31]};
    sum_v        = {1'b0, sum_r} + {1'b0, q_r};

    if (cfg_we) begin
      if (cfg_index == CFG_LAGS) begin
        lags_cfg_nxt = cfg_data[8:0];
      end else begin
        norm_nxt = cfg_data;
      end
    end

    if (cmd.accept) begin
      if (req_type == REQ_LOAD) begin
        if (int'(lag_index) < MAX_LAGS) begin
          coef_we    = 1'b1;
          loaded_nxt = 1'b1;
        end
      end else if (req_type == REQ_PUSH || req_type == REQ_EVAL) begin
        hist_we  = 1'b1;
        head_nxt = head_inc;
        if (hist_cnt_r != CW'(DEPTH)) begin
          hist_cnt_nxt = hist_cnt_r + 1'b1;
        end
        if (req_type == REQ_EVAL) begin
          r0_nxt    = sample_re;
          i0_nxt    = sample_im;
          cbase_nxt = CAW'(int'(tmpl) * MAX_LAGS);
          lags_nxt  = (int'(lags_cfg_r) > MAX_LAGS) ? KW'(MAX_LAGS) : KW'(lags_cfg_r);
          k_nxt     = '0;
          hptr_nxt  = head_r;
          sum_nxt   = '0;
          sat_nxt   = 1'b0;
          dof_nxt   = '0;
        end
      end
    end

    unique case (cmd.op)
      OP_M2_R: begin
        mul_a = 33'(r0_r);
        mul_b = 33'(r0_r);
      end
      OP_M2_I: begin
        m2_nxt = prod_r[31:0];
        mul_a  = 33'(i0_r);
        mul_b  = 33'(i0_r);
      end
      OP_M2_SUM: m2_nxt = m2_r + prod_r[31:0];
      OP_LD: begin
        c_nxt  = coef_rd;
        rk_nxt = hist_ok ? hist_rd[15:0] : '0;
        ik_nxt = hist_ok ? hist_rd[31:16] : '0;
      end
      OP_CC: begin
        mul_a = 33'(c_r);
        mul_b = 33'(c_r);
      end
      OP_DEN1: begin
        den1_nxt = ONE_Q30 - prod_r[30:0];
        mul_a    = 33'(rk_r);
        mul_b    = 33'(r0_r);
      end
      OP_P0: begin
        p_nxt = signed'(prod_r[32:0]);
        mul_a = 33'(ik_r);
        mul_b = 33'(i0_r);
      end
      OP_P1: begin
        p_nxt = p_r + signed'(prod_r[32:0]);
        mul_a = 33'(c_r);
        mul_b = signed'({1'b0, m2_r});
      end
      OP_A: ua_nxt = a_v[48] ? 48'(-a_v) : 48'(a_v);
      OP_Z_SQ: begin
        mul_a = 33'(rk_r);
        mul_b = 33'(rk_r);
      end
      OP_Z_X: begin
        mul_a = signed'(prod_r[32:0]);
        mul_b = signed'({9'd0, norm_r});
      end
      OP_Z_NUM: begin
        num_nxt = NUM_W'(prod_r[55:0]) << 30;
        den_nxt = DEN_W'(den1_r);
      end
      OP_S_LL: begin
        mul_a = signed'({9'd0, ua_r[23:0]});
        mul_b = signed'({9'd0, ua_r[23:0]});
      end
      OP_S_LH: begin
        sq_nxt = SQ_W'(prod_r[47:0]);
        mul_a  = signed'({9'd0, ua_r[23:0]});
        mul_b  = signed'({9'd0, ua_r[47:24]});
      end
      OP_S_HH: begin
        // The cross term counts twice.
        sq_nxt = sq_r + (SQ_W'(prod_r[47:0]) << 25);
        mul_a  = signed'({9'd0, ua_r[47:24]});
        mul_b  = signed'({9'd0, ua_r[47:24]});
      end
      OP_S_SQ: sq_nxt = sq_r + (SQ_W'(prod_r[47:0]) << 48);
      OP_N0: begin
        mul_a = signed'({9'd0, sq_r[23:0]});
        mul_b = signed'({9'd0, norm_r});
      end
      OP_N1: begin
        num_nxt = NUM_W'(prod_r[47:0]);
        mul_a   = signed'({9'd0, sq_r[47:24]});
        mul_b   = signed'({9'd0, norm_r});
      end
      OP_N2: begin
        num_nxt = num_r + (NUM_W'(prod_r[47:0]) << 24);
        mul_a   = signed'({9'd0, sq_r[71:48]});
        mul_b   = signed'({9'd0, norm_r});
      end
      OP_N3: begin
        num_nxt = num_r + (NUM_W'(prod_r[47:0]) << 48);
        mul_a   = signed'({9'd0, sq_r[95:72]});
        mul_b   = signed'({9'd0, norm_r});
      end
      OP_N4: begin
        num_nxt = num_r + (NUM_W'(prod_r[47:0]) << 72);
        mul_a   = signed'({1'b0, m2_r});
        mul_b   = signed'({2'd0, den1_r});
      end
      OP_DEN: den_nxt = prod_r[DEN_W-1:0];
      OP_DIV_INIT: begin
        // A quotient of 2^32 or more, or a zero divisor, saturates the term.
        tsat_nxt = (den_r == '0) || (num_r[NUM_W-1:32] >= (NUM_W - 32)'(den_r));
        rem_nxt  = num_r[DEN_W+31:32];
        q_nxt    = '0;
      end
      OP_DIV_STEP: begin
        num_nxt = {num_r[NUM_W-1:32], num_r[30:0], 1'b0};
        if (rem2 >= {1'b0, den_r}) begin
          rem_nxt = DEN_W'(rem2 - {1'b0, den_r});
          q_nxt   = {q_r[Q_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem2[DEN_W-1:0];
          q_nxt   = {q_r[Q_W-2:0], 1'b0};
        end
      end
      OP_ACC: begin
        dof_nxt  = dof_r + 9'd1;
        k_nxt    = k_r + 1'b1;
        hptr_nxt = (hptr_r == '0) ? HW'(DEPTH - 1) : hptr_r - 1'b1;
        if (tsat_r) begin
          sat_nxt = 1'b1;
        end else if (!sat_r) begin
          if (sum_v[32]) begin
            sat_nxt = 1'b1;
          end else begin
            sum_nxt = sum_v[31:0];
          end
        end
      end
      default: begin
      end
    endcase

    if (cmd.out_load) begin
      if (cmd.out_nl) begin
        chisq_nxt = '0;
        dofo_nxt  = '0;
        stat_nxt  = STAT_NOT_LOADED;
      end else begin
        chisq_nxt = sat_r ? 32'hFFFF_FFFF : sum_r;
        dofo_nxt  = dof_r;
        stat_nxt  = sat_r ? STAT_SAT : STAT_OK;
      end
    end
  end

endmodule

### rtl/acv_checker.sv
`timescale 1ns / 1ps

module acv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import acv_pkg::*;

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == STAT_OK || out_tuser == STAT_NOT_LOADED ||
                    out_tuser == STAT_SAT))
    else $error("unknown status code");

  a_not_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == STAT_NOT_LOADED) |-> (out_tdata[40:0] == '0))
    else $error("empty-table result is not zero");

  a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == STAT_SAT) |-> (out_tdata[31:0] == 32'hFFFF_FFFF))
    else $error("saturated result is not all ones");

  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser != REQ_EVAL && !out_tvalid) |=> !out_tvalid)
    else $error("load or push transaction produced a result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind autocorr_chisq_veto acv_checker u_acv_checker (.*);
